FILE: design/spq_pkg.sv
// shared types, codes and widths for the stable priority task queue
`timescale 1ns / 1ps

package spq_pkg;

  localparam int HANDLE_W            = 32;
  localparam int ARG_W               = 32;
  localparam int PRIO_W              = 8;
  localparam int STATUS_W            = 2;
  localparam int OCC_W               = 5;
  localparam int DEFAULT_QUEUE_DEPTH = 16;

  localparam logic KIND_SUBMIT = 1'b0;
  localparam logic KIND_TAKE   = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic                kind;
    logic [HANDLE_W-1:0] task_handle;
    logic [ARG_W-1:0]    task_arg;
    logic [PRIO_W-1:0]   priority_req;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [HANDLE_W-1:0] out_handle;
    logic [ARG_W-1:0]    out_arg;
    logic [PRIO_W-1:0]   out_priority;
    logic [OCC_W-1:0]    occupancy;
  } rsp_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [ARG_W-1:0]    arg;
    logic [PRIO_W-1:0]   prio;
  } entry_t;

  typedef struct packed {
    logic accept;
    logic scan_step;
    logic shift_start;
    logic shift_step;
    logic respond;
  } cmd_t;

  typedef struct packed {
    logic take_ready;
    logic scan_done;
    logic shift_done;
    logic out_free;
  } stat_t;

endpackage

FILE: design/spq_if.sv
// request and result channel interfaces
`timescale 1ns / 1ps

interface spq_req_if import spq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                kind;
  logic [HANDLE_W-1:0] task_handle;
  logic [ARG_W-1:0]    task_arg;
  logic [PRIO_W-1:0]   priority_req;

  modport source (output valid, output kind, output task_handle, output task_arg,
                  output priority_req, input ready);
  modport sink (input valid, input kind, input task_handle, input task_arg,
                input priority_req, output ready);
endinterface

interface spq_rsp_if import spq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [HANDLE_W-1:0] out_handle;
  logic [ARG_W-1:0]    out_arg;
  logic [PRIO_W-1:0]   out_priority;
  logic [OCC_W-1:0]    occupancy;

  modport source (output valid, output status, output out_handle, output out_arg,
                  output out_priority, output occupancy, input ready);
  modport sink (input valid, input status, input out_handle, input out_arg,
                input out_priority, input occupancy, output ready);
endinterface

FILE: design/spq_ctrl.sv
// sequencer for submit, scan and compaction
`timescale 1ns / 1ps

module spq_ctrl import spq_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  req_valid,
  output logic  req_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;
  localparam logic [1:0] S_RESP  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    unique case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.accept = 1'b1;
          state_next = stat.take_ready ? S_SCAN : S_RESP;
        end
      end
      S_SCAN: begin
        if (stat.scan_done) begin
          cmd.shift_start = 1'b1;
          state_next      = S_SHIFT;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_SHIFT: begin
        if (stat.shift_done) begin
          state_next = S_RESP;
        end else begin
          cmd.shift_step = 1'b1;
        end
      end
      S_RESP: begin
        if (stat.out_free) begin
          cmd.respond = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: design/spq_dp.sv
// entry memory, search registers, count and result register
`timescale 1ns / 1ps

module spq_dp import spq_pkg::*; #(
  parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
  input  logic  clk,
  input  logic  rst,
  input  req_t  req_in,
  input  cmd_t  cmd,
  output stat_t stat,
  output logic  rsp_valid,
  input  logic  rsp_ready,
  output rsp_t  rsp_out
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  entry_t mem [QUEUE_DEPTH];
  entry_t rd_data;

  logic [CW-1:0]       count;
  logic [CW-1:0]       ptr;
  logic                pend;
  logic [AW-1:0]       pend_idx;
  logic [AW-1:0]       best_idx;
  logic [PRIO_W-1:0]   best_prio;
  logic [HANDLE_W-1:0] best_handle;
  logic [ARG_W-1:0]    best_arg;
  req_t                req_q;
  logic                out_valid;
  rsp_t                rsp_q;
  rsp_t                rsp_next;
  logic [CW-1:0]       count_next;

  logic          stepping;
  logic          issue;
  logic          full;
  logic          we;
  logic [AW-1:0] wa;
  entry_t        wd;
  logic          better;

  assign stepping = cmd.scan_step | cmd.shift_step;
  assign issue    = stepping && (ptr < count);
  assign full     = (count == CW'(QUEUE_DEPTH));
  assign better   = pend && ((pend_idx == '0) || (rd_data.prio > best_prio));

  always_comb begin
    we = 1'b0;
    wa = count[AW-1:0];
    wd = '{handle: req_q.task_handle, arg: req_q.task_arg, prio: req_q.priority_req};
    if (cmd.respond && (req_q.kind == KIND_SUBMIT) && !full) begin
      we = 1'b1;
    end else if (cmd.shift_step && pend) begin
      we = 1'b1;
      wa = pend_idx - AW'(1);
      wd = rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (issue) begin
      rd_data <= mem[ptr[AW-1:0]];
    end
  end

  always_comb begin
    count_next = count;
    rsp_next   = '0;
    if (req_q.kind == KIND_SUBMIT) begin
      if (full) begin
        rsp_next.status = ST_FULL;
      end else begin
        rsp_next.status = ST_OK;
        count_next      = count + CW'(1);
      end
    end else if (count == '0) begin
      rsp_next.status = ST_EMPTY;
    end else begin
      rsp_next.status       = ST_OK;
      rsp_next.out_handle   = best_handle;
      rsp_next.out_arg      = best_arg;
      rsp_next.out_priority = best_prio;
      count_next            = count - CW'(1);
    end
    rsp_next.occupancy = OCC_W'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.respond) begin
        count <= count_next;
      end
      if (cmd.accept) begin
        pend <= 1'b0;
      end else if (stepping) begin
        pend <= issue;
      end
      if (cmd.respond) begin
        out_valid <= 1'b1;
      end else if (rsp_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_q <= req_in;
      ptr   <= '0;
    end else if (cmd.shift_start) begin
      ptr <= CW'(best_idx) + CW'(1);
    end else if (issue) begin
      ptr <= ptr + CW'(1);
    end
    if (issue) begin
      pend_idx <= ptr[AW-1:0];
    end
    if (cmd.scan_step && better) begin
      best_idx    <= pend_idx;
      best_prio   <= rd_data.prio;
      best_handle <= rd_data.handle;
      best_arg    <= rd_data.arg;
    end
    if (cmd.respond) begin
      rsp_q <= rsp_next;
    end
  end

  assign stat.take_ready = (req_in.kind == KIND_TAKE) && (count != '0);
  assign stat.scan_done  = (ptr >= count) && !pend;
  assign stat.shift_done = (ptr >= count) && !pend;
  assign stat.out_free   = !out_valid || rsp_ready;

  assign rsp_valid = out_valid;
  assign rsp_out   = rsp_q;

endmodule

FILE: design/stable_priority_task_queue.sv
// stable priority task queue top level
// usage:
//   req channel carries one request: kind 0 submits (task_handle, task_arg,
//   priority_req), kind 1 takes the highest-priority task, earliest on ties
//   rsp channel returns one result per request: status, taken task fields
//   (zero unless a take succeeded) and occupancy after the request
// timing:
//   one request is in flight at a time; req.ready is high only when idle,
//   and the next request is taken the cycle after a result is loaded
//   submit and empty take: accept goes straight to the result state, which loads
//   the result once the output register is free; take with n queued tasks, winner
//   at position k from the head (0 first): the search reads one entry per cycle
//   through the single read port of the entry memory, first the priority scan,
//   then the compaction of the entries behind k, before the result state
// reset:
//   rst clears the queue to empty and drops any pending result
// stall:
//   a result waits in the output register until rsp.ready; the next request
//   is still accepted and worked on, and its result is held back until the
//   output register is free
`timescale 1ns / 1ps

module stable_priority_task_queue import spq_pkg::*; #(
  parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
  input logic          clk,
  input logic          rst,
  spq_req_if.sink      req,
  spq_rsp_if.source    rsp
);

  cmd_t  cmd;
  stat_t stat;
  req_t  req_in;
  rsp_t  rsp_out;
  logic  ready;

  assign req_in = '{kind: req.kind, task_handle: req.task_handle, task_arg: req.task_arg,
                    priority_req: req.priority_req};
  assign req.ready = ready;

  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  spq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req_in    (req_in),
    .cmd       (cmd),
    .stat      (stat),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_out   (rsp_out)
  );

  assign rsp.status       = rsp_out.status;
  assign rsp.out_handle   = rsp_out.out_handle;
  assign rsp.out_arg      = rsp_out.out_arg;
  assign rsp.out_priority = rsp_out.out_priority;
  assign rsp.occupancy    = rsp_out.occupancy;

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.respond |-> stat.out_free)
    else $error("result register overwritten while occupied");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("second request accepted while busy");

  a_one_command: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.accept, cmd.scan_step, cmd.shift_step, cmd.respond}))
    else $error("conflicting datapath commands");

  a_empty_occupancy: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && (rsp.status == ST_EMPTY)) |-> (rsp.occupancy == '0))
    else $error("empty status with nonzero occupancy");

endmodule
